FILE: sv/csrd_pkg.sv
// Shared types, constants and a small helper for the colorspace read decoder.
package csrd_pkg;

  localparam int unsigned POS_W  = 11;
  localparam int unsigned CODE_W = 3;
  localparam int unsigned QIN_W  = 7;
  localparam int unsigned QOUT_W = 8;

  localparam logic [CODE_W-1:0] CODE_N       = 3'd4;
  localparam logic [QOUT_W-1:0] QUAL_OFFSET  = 8'd33;
  localparam logic [QOUT_W-1:0] QUAL_MAX     = 8'd127;

  typedef struct packed {
    logic [POS_W-1:0]  nuc_pos;
    logic [CODE_W-1:0] nuc;
    logic [POS_W-1:0]  qual_pos;
    logic [QOUT_W-1:0] qual;
    logic              eor;
  } res_t;

  typedef struct packed {
    logic [CODE_W-1:0] prev_nuc;
    logic signed [7:0] prev_phred;
    logic [CODE_W-1:0] upstream;
  } dec_state_t;

  function automatic logic [CODE_W-1:0] norm_code(input logic [CODE_W-1:0] v);
    return (v > CODE_N) ? CODE_N : v;
  endfunction

endpackage

FILE: sv/csrd_decode.sv
// Combinational decode of one color: nucleotide, qualities and next decoder state.
module csrd_decode (
  input  logic [csrd_pkg::CODE_W-1:0] color_code,
  input  logic [csrd_pkg::QIN_W-1:0]  quality_byte,
  input  logic                        miscalled,
  input  logic [csrd_pkg::CODE_W-1:0] corrected_color,
  input  logic [csrd_pkg::CODE_W-1:0] upstream_nuc,
  input  logic                        first_color,
  input  logic                        last_color,
  input  csrd_pkg::dec_state_t        state_cur,
  input  logic [csrd_pkg::POS_W-1:0]  pos_cur,
  input  logic [csrd_pkg::POS_W-1:0]  pos_next,
  output csrd_pkg::res_t              res0,
  output csrd_pkg::res_t              res1,
  output csrd_pkg::dec_state_t        state_nxt
);
  import csrd_pkg::*;

  logic [CODE_W-1:0] col, up, prev_nuc, upstream, nuc;
  logic signed [8:0] phred_raw, phred, prev_ph, qsum;
  logic [6:0]        qclamp, fclamp;
  logic [QOUT_W-1:0] fq;

  always_comb begin
    up        = norm_code(upstream_nuc);
    col       = miscalled ? norm_code(corrected_color) : norm_code(color_code);
    phred_raw = $signed({2'b00, quality_byte}) - 9'sd33;
    phred     = miscalled ? -phred_raw : phred_raw;

    // A first color restarts the read before it is decoded.
    prev_nuc = first_color ? up : state_cur.prev_nuc;
    upstream = first_color ? up : state_cur.upstream;
    prev_ph  = first_color ? 9'sd0 : 9'(state_cur.prev_phred);

    nuc = (prev_nuc >= CODE_N || col >= CODE_N) ? CODE_N : (prev_nuc ^ col);

    qsum = phred + prev_ph;
    if (qsum < 0) begin
      qclamp = 7'd0;
    end else if (qsum > 9'sd127) begin
      qclamp = 7'd127;
    end else begin
      qclamp = qsum[6:0];
    end

    fclamp = (phred < 0) ? 7'd0 : phred[6:0];
    fq     = {1'b0, fclamp} + QUAL_OFFSET;
    if (fq > QUAL_MAX) begin
      fq = QUAL_MAX;
    end

    res0.nuc_pos  = pos_next;
    res0.nuc      = nuc;
    res0.qual_pos = pos_cur;
    res0.qual     = {1'b0, qclamp} + QUAL_OFFSET;
    res0.eor      = 1'b0;

    res1.nuc_pos  = '0;
    res1.nuc      = upstream;
    res1.qual_pos = pos_next;
    res1.qual     = fq;
    res1.eor      = 1'b1;

    state_nxt.prev_nuc   = nuc;
    state_nxt.upstream   = upstream;
    state_nxt.prev_phred = last_color ? 8'sd0 : phred[7:0];
  end

endmodule

FILE: sv/csrd_outq.sv
// Four-entry result queue that takes one or two results a cycle and gives one.
module csrd_outq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  logic           push_two,
  input  csrd_pkg::res_t wr0,
  input  csrd_pkg::res_t wr1,
  output logic           room_two,
  output logic           rd_valid,
  input  logic           rd_ready,
  output csrd_pkg::res_t rd_data
);
  import csrd_pkg::*;

  localparam int unsigned DEPTH = 4;

  res_t       mem [DEPTH];
  logic [1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       pop;

  assign pop      = rd_valid && rd_ready;
  assign rd_valid = (count_r != 3'd0);
  assign rd_data  = mem[rptr_r];
  assign room_two = (count_r <= 3'(DEPTH - 2));

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt  = push_two ? wptr_r + 2'd2 : wptr_r + 2'd1;
      count_nxt = push_two ? count_nxt + 3'd2 : count_nxt + 3'd1;
    end
    if (pop) begin
      rptr_nxt  = rptr_r + 2'd1;
      count_nxt = count_nxt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= wr0;
      if (push_two) begin
        mem[wptr_r + 2'd1] <= wr1;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 3'(DEPTH))
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_two) |-> room_two)
    else $error("two results pushed without room");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> count_r == $past(count_r) - 3'd1)
    else $error("queue count did not drop on a lone pop");

endmodule

FILE: sv/color_space_read_decoder_top.sv
// Top level of the colorspace read decoder: read state, decode and result queue.
//
//   channel | direction | ports
//   in_     | input     | in_valid, in_ready, color and quality fields of one color
//   out_    | output    | out_valid, out_ready, positions, nucleotide, quality, end mark
//
// One color is accepted per cycle while in_ready is high; its result is in the queue the next cycle.
// The last color of a read yields two results, so a read of L colors yields
// L+1 results; the queue gives out one result a cycle while out_ready is high.
// in_ready is high while the queue has room for two results.
// Synchronous active-low reset clears the read state and empties the queue.
module color_space_read_decoder_top #(
  parameter int unsigned MAX_READ_LEN = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [csrd_pkg::CODE_W-1:0] in_color_code,
  input  logic [csrd_pkg::QIN_W-1:0]  in_quality_byte,
  input  logic                        in_miscalled,
  input  logic [csrd_pkg::CODE_W-1:0] in_corrected_color,
  input  logic [csrd_pkg::CODE_W-1:0] in_upstream_nuc,
  input  logic                        in_first_color,
  input  logic                        in_last_color,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [csrd_pkg::POS_W-1:0]  out_nuc_position,
  output logic [csrd_pkg::CODE_W-1:0] out_nucleotide,
  output logic [csrd_pkg::POS_W-1:0]  out_qual_position,
  output logic [csrd_pkg::QOUT_W-1:0] out_decoded_quality,
  output logic                        out_end_of_read
);
  import csrd_pkg::*;

  localparam int unsigned CIDX_W = (MAX_READ_LEN > 1) ? $clog2(MAX_READ_LEN) : 1;
  localparam int unsigned WIDE_W = (CIDX_W + 1 > POS_W) ? CIDX_W + 1 : POS_W;
  localparam logic [CIDX_W-1:0] IDX_LAST = CIDX_W'(MAX_READ_LEN - 1);

  logic              accept;
  dec_state_t        state_r, state_nxt;
  logic [CIDX_W-1:0] idx_r, idx_nxt, idx_eff;
  logic [WIDE_W-1:0] idx_wide, idx_wide_inc;
  logic [POS_W-1:0]  pos_cur, pos_next;
  res_t              res0, res1, head;
  logic              room_two;

  assign accept   = in_valid && in_ready;
  assign in_ready = room_two;

  // Positions are the color index and its successor, cut to the port width.
  assign idx_eff      = in_first_color ? '0 : idx_r;
  assign idx_wide     = WIDE_W'(idx_eff);
  assign idx_wide_inc = idx_wide + WIDE_W'(1);
  assign pos_cur      = idx_wide[POS_W-1:0];
  assign pos_next     = idx_wide_inc[POS_W-1:0];

  always_comb begin
    if (in_last_color) begin
      idx_nxt = '0;
    end else if (idx_eff < IDX_LAST) begin
      idx_nxt = idx_eff + CIDX_W'(1);
    end else begin
      idx_nxt = idx_eff;
    end
  end

  csrd_decode u_decode (
    .color_code      (in_color_code),
    .quality_byte    (in_quality_byte),
    .miscalled       (in_miscalled),
    .corrected_color (in_corrected_color),
    .upstream_nuc    (in_upstream_nuc),
    .first_color     (in_first_color),
    .last_color      (in_last_color),
    .state_cur       (state_r),
    .pos_cur         (pos_cur),
    .pos_next        (pos_next),
    .res0            (res0),
    .res1            (res1),
    .state_nxt       (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
      idx_r   <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  csrd_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_two (in_last_color),
    .wr0      (res0),
    .wr1      (res1),
    .room_two (room_two),
    .rd_valid (out_valid),
    .rd_ready (out_ready),
    .rd_data  (head)
  );

  assign out_nuc_position    = head.nuc_pos;
  assign out_nucleotide      = head.nuc;
  assign out_qual_position   = head.qual_pos;
  assign out_decoded_quality = head.qual;
  assign out_end_of_read     = head.eor;

endmodule
